// ===== design/frie_pkg.sv =====
// Package for the four-register instruction executor.
// Holds operation and fault codes and default sizes; no dependencies.
`default_nettype none
package frie_pkg;
  localparam int NumRegsDef   = 4;
  localparam int MemWordsDef  = 1024;
  localparam int DataWidthDef = 32;

  localparam logic [3:0] OP_MOV   = 4'd0;
  localparam logic [3:0] OP_ADD   = 4'd1;
  localparam logic [3:0] OP_SUB   = 4'd2;
  localparam logic [3:0] OP_MUL   = 4'd3;
  localparam logic [3:0] OP_DIV   = 4'd4;
  localparam logic [3:0] OP_LOAD  = 4'd5;
  localparam logic [3:0] OP_STORE = 4'd6;
  localparam logic [3:0] OP_JMP   = 4'd7;
  localparam logic [3:0] OP_JMPZ  = 4'd8;

  localparam logic [1:0] FLT_OK   = 2'd0;
  localparam logic [1:0] FLT_DIV0 = 2'd1;
  localparam logic [1:0] FLT_ADDR = 2'd2;
  localparam logic [1:0] FLT_JNEG = 2'd3;
endpackage
`default_nettype wire

// ===== design/four_register_instruction_executor_unit.sv =====
// Four-register instruction executor: in_ takes one decoded instruction per
// beat, out_ returns one result beat per instruction.
//
// After reset a clearing pass writes zero to every memory word, one word per
// cycle (MEM_WORDS words, 1024 by default); in_tready stays low meanwhile.
// Each instruction then passes an accept state, a setup state, DATA_WIDTH
// serial steps in which the operation is done one bit per cycle (shift-add
// multiply, restoring divide, bit-serial add/sub/move), and a finish state
// that waits in a hold state while the output register is still full.
// Load, store, jumps and unused codes skip the serial steps.
// One instruction is in work at a time. The result sits in an output
// register; the next beat is accepted while it waits, and its own result is
// held until out_tready takes the earlier one.
// in_tdata, low bit up: operation[3:0], use_immediate, dest_reg[1:0],
// src_reg[1:0], immediate[31:0], zero fill to 48 bits.
// out_tdata, low bit up: next_pc[15:0], r0_value[31:0], result_value[31:0],
// fault[1:0], zero fill to 88 bits.
`default_nettype none
module four_register_instruction_executor_unit #(
  parameter int NUM_REGS   = frie_pkg::NumRegsDef,
  parameter int MEM_WORDS  = frie_pkg::MemWordsDef,
  parameter int DATA_WIDTH = frie_pkg::DataWidthDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // operation, use_immediate, dest, src, immediate
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [87:0]      out_tdata   // next_pc, r0_value, result_value, fault
);
  import frie_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int AW = $clog2(MEM_WORDS);
  localparam int CW = $clog2(DW + 1);
  localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_RUN  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;
  localparam logic [2:0] ST_HOLD = 3'd5;

  logic [2:0]  st_r;
  logic [AW:0] clr_r;
  logic [DW-1:0] rf_r [NUM_REGS];
  logic [15:0] pc_r;

  // instruction latch
  logic [3:0]  op_r;
  logic [RW-1:0] d_r;
  logic [31:0] imm_r;
  // serial datapath
  logic [DW-1:0] a_r, b_r, acc_r, q_r;
  logic [DW:0]   rem_r;
  logic [CW-1:0] cnt_r;
  logic          cy_r, na_r, nb_r;
  // output
  logic          ov_r;
  logic [87:0]   od_r;

  logic [3:0]  i_op;
  logic        i_ui;
  logic [1:0]  i_d, i_s;
  logic [31:0] i_imm;
  assign i_op  = in_tdata[3:0];
  assign i_ui  = in_tdata[4];
  assign i_d   = in_tdata[6:5];
  assign i_s   = in_tdata[8:7];
  assign i_imm = in_tdata[40:9];

  // fold a 2-bit index into the register count (one subtract covers it)
  logic [RW-1:0] di, si;
  assign di = RW'((32'(i_d) >= NUM_REGS) ? 32'(i_d) - NUM_REGS : 32'(i_d));
  assign si = RW'((32'(i_s) >= NUM_REGS) ? 32'(i_s) - NUM_REGS : 32'(i_s));

  logic [DW-1:0] immd;
  assign immd = DW'({{32{i_imm[31]}}, i_imm});

  logic addr_ok;
  assign addr_ok = !imm_r[31] && ({1'b0, imm_r} < 33'(MEM_WORDS));

  // memory port
  logic          m_we;
  logic [AW-1:0] m_addr;
  logic [DW-1:0] m_wd, m_rd;
  always_comb begin
    m_we = 1'b0;
    m_addr = imm_r[AW-1:0];
    m_wd = rf_r[d_r];
    if (st_r == ST_CLR) begin
      m_we = 1'b1;
      m_addr = clr_r[AW-1:0];
      m_wd = '0;
    end else if (st_r == ST_FIN && op_r == OP_STORE && addr_ok) begin
      m_we = 1'b1;
    end
  end

  frie_ram #(.Width(DW), .Depth(MEM_WORDS)) u_ram (
    .clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wd), .rdata(m_rd)
  );

  // one serial step
  logic [DW:0] rsh, rdf;
  logic        sbit;
  logic [DW-1:0] macc;
  always_comb begin
    rsh  = {rem_r[DW-1:0], a_r[DW-1]};
    rdf  = rsh - {1'b0, b_r};
    macc = acc_r + (b_r[0] ? a_r : '0);
    case (op_r)
      OP_ADD:  sbit = a_r[0] ^ b_r[0] ^ cy_r;
      OP_SUB:  sbit = a_r[0] ^ ~b_r[0] ^ cy_r;
      default: sbit = b_r[0];
    endcase
  end

  logic out_free;
  assign out_free = !ov_r || out_tready;
  assign in_tready = (st_r == ST_IDLE);

  logic fin_go;
  assign fin_go = (st_r == ST_FIN || st_r == ST_HOLD) && out_free;

  // finish: compute outcome
  logic [DW-1:0] res;
  logic [1:0]    flt;
  logic          wr_rf, jmp_t;
  logic [DW-1:0] qs;
  always_comb begin
    res = '0; flt = FLT_OK; wr_rf = 1'b0; jmp_t = 1'b0;
    qs = (na_r ^ nb_r) ? (~q_r + 1'b1) : q_r;
    case (op_r)
      OP_MOV, OP_ADD, OP_SUB: begin res = acc_r; wr_rf = 1'b1; end
      OP_MUL: begin res = acc_r; wr_rf = 1'b1; end
      OP_DIV: begin
        if (cy_r) flt = FLT_DIV0;
        else begin res = qs; wr_rf = 1'b1; end
      end
      OP_LOAD: begin
        if (!addr_ok) flt = FLT_ADDR;
        else begin res = m_rd; wr_rf = 1'b1; end
      end
      OP_STORE: begin
        if (!addr_ok) flt = FLT_ADDR;
        else res = rf_r[d_r];
      end
      OP_JMP, OP_JMPZ: begin
        if (op_r == OP_JMP || rf_r[0] == '0) begin
          if (imm_r[31]) flt = FLT_JNEG;
          else jmp_t = 1'b1;
        end
      end
      default: ;
    endcase
  end

  logic [15:0] pc_n;
  assign pc_n = (flt != FLT_OK) ? pc_r : (jmp_t ? imm_r[15:0] : pc_r + 16'd1);
  logic [DW-1:0] r0_n;
  always_comb begin
    r0_n = rf_r[0];
    if (wr_rf && flt == FLT_OK && d_r == '0) r0_n = res;
  end

  // control and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLR;
      clr_r <= '0;
      pc_r <= '0;
      ov_r <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) rf_r[i] <= '0;
    end else begin
      // load a new result or drop the taken one
      if (fin_go) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
      case (st_r)
        ST_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (AW+1)'(MEM_WORDS - 1)) st_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_tvalid) begin
            op_r <= i_op; d_r <= di; imm_r <= i_imm;
            a_r <= rf_r[di];
            b_r <= i_ui ? immd : rf_r[si];
            st_r <= ST_RD;
          end
        end
        ST_RD: begin
          // set up the serial loop
          cnt_r <= '0;
          acc_r <= '0;
          rem_r <= '0;
          q_r <= '0;
          cy_r <= (op_r == OP_DIV) ? (b_r == '0) : (op_r == OP_SUB);
          na_r <= (op_r == OP_DIV) && a_r[DW-1];
          nb_r <= (op_r == OP_DIV) && b_r[DW-1];
          if (op_r == OP_DIV) begin
            a_r <= a_r[DW-1] ? (~a_r + 1'b1) : a_r;
            b_r <= b_r[DW-1] ? (~b_r + 1'b1) : b_r;
          end
          st_r <= (op_r <= OP_DIV) ? ST_RUN : ST_FIN;
        end
        ST_RUN: begin
          cnt_r <= cnt_r + 1'b1;
          case (op_r)
            OP_MUL: begin
              acc_r <= macc;
              a_r <= {a_r[DW-2:0], 1'b0};
              b_r <= {1'b0, b_r[DW-1:1]};
            end
            OP_DIV: begin
              a_r <= {a_r[DW-2:0], 1'b0};
              if (!rdf[DW]) begin
                rem_r <= rdf; q_r <= {q_r[DW-2:0], 1'b1};
              end else begin
                rem_r <= rsh; q_r <= {q_r[DW-2:0], 1'b0};
              end
            end
            default: begin
              acc_r <= {sbit, acc_r[DW-1:1]};
              a_r <= {a_r[0], a_r[DW-1:1]};
              b_r <= {b_r[0], b_r[DW-1:1]};
              cy_r <= (op_r == OP_ADD) ?
                ((a_r[0] & b_r[0]) | (cy_r & (a_r[0] ^ b_r[0]))) :
                ((a_r[0] & ~b_r[0]) | (cy_r & (a_r[0] ^ ~b_r[0])));
            end
          endcase
          if (cnt_r == CW'(DW - 1)) begin
            st_r <= ST_FIN;
            if (op_r == OP_DIV) b_r <= (cy_r) ? '0 : b_r;
          end
        end
        ST_FIN, ST_HOLD: begin
          if (out_free) begin
            if (flt == FLT_OK) begin
              pc_r <= pc_n;
              if (wr_rf) rf_r[d_r] <= res;
            end
            od_r <= {6'd0, flt, 32'({{32{res[DW-1]}}, res}),
                     32'({{32{r0_n[DW-1]}}, r0_n}), pc_n};
            st_r <= ST_IDLE;
          end else st_r <= ST_HOLD;
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

`ifndef SYNTHESIS
  a_no_in_clr: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_CLR |-> !in_tready) else $error("accept during clear");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_tready |=> ov_r) else $error("result dropped");
  a_fin_one: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_RUN && op_r > OP_DIV |-> 1'b0) else $error("bad run op");
`endif
endmodule
`default_nettype wire

// ===== design/frie_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module frie_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write one word and read one word
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== tb/sv/tb_four_register_instruction_executor_unit.sv =====
// Testbench for four_register_instruction_executor_unit: drives decoded
// instructions, predicts each result from a private machine state and checks it.
// Depends on frie_pkg and the unit's RTL only.
`default_nettype none
module tb_four_register_instruction_executor_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import frie_pkg::*;

  localparam int MemWords = 1024;
  localparam int WatchLimit = 20000;

  typedef struct packed {
    logic [1:0]  fault;
    logic [31:0] result_value;
    logic [31:0] r0_value;
    logic [15:0] next_pc;
  } exec_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;

  four_register_instruction_executor_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predicted machine state
  logic [31:0]  regs_q [4];
  logic [31:0]  mem_q [MemWords];
  logic [15:0]  pc_q;
  exec_result_t pending_results[$];
  int           mismatches = 0;
  int           idle_pct = 6;
  int           idle_cycles = 0;

  // compute one instruction's result and advance the predicted state
  function automatic exec_result_t execute_instr(logic [3:0] op, logic imm_sel,
      logic [1:0] d, logic [1:0] s, logic signed [31:0] imm);
    exec_result_t r;
    logic [31:0] a, b, val;
    logic [15:0] pc_next;
    logic [1:0] flt;
    a = regs_q[d];
    b = imm_sel ? imm : regs_q[s];
    val = '0;
    flt = FLT_OK;
    pc_next = pc_q + 16'd1;
    case (op)
      OP_MOV: val = b;
      OP_ADD: val = a + b;
      OP_SUB: val = a - b;
      OP_MUL: val = a * b;
      OP_DIV: begin
        if (b == 0) flt = FLT_DIV0;
        else if (b == 32'hFFFF_FFFF) val = -a;
        else val = $signed(a) / $signed(b);
      end
      OP_LOAD, OP_STORE: begin
        if (imm < 0 || imm >= MemWords) flt = FLT_ADDR;
        else if (op == OP_LOAD) val = mem_q[imm[9:0]];
        else val = a;
      end
      OP_JMP, OP_JMPZ: begin
        if (op == OP_JMP || regs_q[0] == 0) begin
          if (imm < 0) flt = FLT_JNEG;
          else pc_next = imm[15:0];
        end
      end
      default: ;
    endcase
    if (flt == FLT_OK) begin
      if (op <= OP_LOAD) regs_q[d] = val;
      if (op == OP_STORE) mem_q[imm[9:0]] = val;
      pc_q = pc_next;
    end else begin
      val = '0;
    end
    r.next_pc = pc_q;
    r.r0_value = regs_q[0];
    r.result_value = val;
    r.fault = flt;
    return r;
  endfunction

  // send one instruction beat, with random idle cycles before it
  task automatic send_instr(logic [3:0] op, logic imm_sel, logic [1:0] d,
      logic [1:0] s, logic [31:0] imm);
    exec_result_t pred;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, imm, s, d, imm_sel, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = execute_instr(op, imm_sel, d, s, imm);
    pending_results = {pending_results, pred};
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // check each result beat against the oldest prediction
  always @(posedge clk) begin
    exec_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[81:0];
      if (out_tdata[87:82] != 0 || pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", out_tdata);
        if (pending_results.size() != 0) void'(pending_results.pop_front());
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp pc=%h r0=%h res=%h flt=%0d, got pc=%h r0=%h res=%h flt=%0d",
                     want.next_pc, want.r0_value, want.result_value, want.fault,
                     got.next_pc, got.r0_value, got.result_value, got.fault);
        end
      end
    end
  end

  // random stall on the result side
  always @(posedge clk) out_tready <= ($urandom_range(99) >= idle_pct);

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("four_register_instruction_executor_unit verification failed");
      $finish;
    end
  end

  task automatic test_arith_extremes();
    logic [3:0] op;
    send_instr(OP_MOV, 1'b1, 2'd0, 2'd0, 32'h8000_0000);
    send_instr(OP_MOV, 1'b1, 2'd1, 2'd0, 32'hFFFF_FFFF);
    send_instr(OP_DIV, 1'b0, 2'd0, 2'd1, 32'd0);
    send_instr(OP_MOV, 1'b1, 2'd2, 2'd0, 32'h7FFF_FFFF);
    send_instr(OP_ADD, 1'b1, 2'd2, 2'd3, 32'd1);
    send_instr(OP_SUB, 1'b0, 2'd2, 2'd1, 32'd0);
    send_instr(OP_MUL, 1'b1, 2'd2, 2'd0, 32'h7FFF_FFFF);
    send_instr(OP_DIV, 1'b1, 2'd2, 2'd0, 32'd0);
    send_instr(OP_DIV, 1'b1, 2'd2, 2'd0, 32'hFFFF_FFF9);
    send_instr(OP_DIV, 1'b0, 2'd3, 2'd3, 32'd0);
    for (int k = 9; k < 16; k++) begin
      op = 4'(k);
      send_instr(op, 1'b1, 2'd3, 2'd3, 32'hA5A5_A5A5);
    end
  endtask

  task automatic test_memory_and_jumps();
    send_instr(OP_STORE, 1'b1, 2'd2, 2'd1, 32'd1023);
    send_instr(OP_LOAD, 1'b0, 2'd3, 2'd0, 32'd1023);
    send_instr(OP_LOAD, 1'b0, 2'd1, 2'd0, 32'd0);
    send_instr(OP_STORE, 1'b0, 2'd1, 2'd0, 32'd1024);
    send_instr(OP_LOAD, 1'b0, 2'd1, 2'd0, 32'hFFFF_FFFF);
    send_instr(OP_JMP, 1'b1, 2'd3, 2'd3, 32'h0001_FFFF);
    send_instr(OP_ADD, 1'b1, 2'd1, 2'd0, 32'd1);
    send_instr(OP_JMP, 1'b0, 2'd0, 2'd0, 32'h8000_0000);
    send_instr(OP_JMPZ, 1'b0, 2'd0, 2'd0, 32'hFFFF_FFFF);
    send_instr(OP_MOV, 1'b1, 2'd0, 2'd0, 32'd0);
    send_instr(OP_JMPZ, 1'b0, 2'd0, 2'd0, 32'hFFFF_FFFF);
    send_instr(OP_JMPZ, 1'b0, 2'd0, 2'd0, 32'd1234);
  endtask

  // mostly valid instructions, with addresses and targets mostly kept in range
  task automatic test_random_program(int count);
    logic [3:0] op;
    logic [31:0] imm;
    for (int n = 0; n < count; n++) begin
      op = $urandom_range(99) < 4 ? 4'($urandom_range(15)) : 4'($urandom_range(8));
      case ($urandom_range(9))
        0: imm = $urandom;
        1: imm = ($urandom_range(1) ? 32'hFFFF_FFFE : 32'h0) | 32'($urandom_range(3));
        2: imm = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        3, 4: imm = $urandom_range(1) ? 32'($urandom_range(2047)) - 32'd512 : 32'd0;
        default: imm = (op == OP_LOAD || op == OP_STORE) ? 32'($urandom_range(15))
                                                       : 32'($urandom_range(65535));
      endcase
      send_instr(op, 1'($urandom), 2'($urandom), 2'($urandom), imm);
    end
  endtask

  initial begin
    for (int k = 0; k < 4; k++) regs_q[k] = '0;
    for (int k = 0; k < MemWords; k++) mem_q[k] = '0;
    pc_q = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_arith_extremes();
    test_memory_and_jumps();
    // hold the sender until every result has drained
    drain_results();
    test_random_program(800);
    idle_pct = 0;
    test_random_program(300);
    idle_pct = 6;
    test_random_program(520);
    drain_results();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("four_register_instruction_executor_unit verification clean");
    end else begin
      $display("four_register_instruction_executor_unit verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
